@@ rtl/pvc_pkg.sv @@
package pvc_pkg;

    localparam int MAX_CHARS = 64;

    // buffer address, fill count and walk pointer widths
    localparam int ADDR_W = $clog2(MAX_CHARS);
    localparam int CNT_W  = $clog2(MAX_CHARS + 1);
    localparam int PTR_W  = $clog2(2 * MAX_CHARS + 1);

    // operation codes
    localparam logic [2:0] OP_LOAD_UA = 3'd0;
    localparam logic [2:0] OP_LOAD_RA = 3'd1;
    localparam logic [2:0] OP_LOAD_UB = 3'd2;
    localparam logic [2:0] OP_LOAD_RB = 3'd3;
    localparam logic [2:0] OP_CMP     = 3'd4;

    // buffer selects, taken from the low bits of a load operation
    localparam logic [1:0] BUF_UA = 2'd0;
    localparam logic [1:0] BUF_RA = 2'd1;
    localparam logic [1:0] BUF_UB = 2'd2;
    localparam logic [1:0] BUF_RB = 2'd3;

    // relation codes
    localparam logic [2:0] REL_NONE = 3'd0;
    localparam logic [2:0] REL_EQ   = 3'd1;
    localparam logic [2:0] REL_LT   = 3'd2;
    localparam logic [2:0] REL_LE   = 3'd3;
    localparam logic [2:0] REL_GT   = 3'd4;
    localparam logic [2:0] REL_GE   = 3'd5;

    typedef logic signed [1:0] t_ord;
    localparam t_ord ORD_LESS    = 2'sb11;
    localparam t_ord ORD_EQ      = 2'sb00;
    localparam t_ord ORD_GREATER = 2'sb01;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [PTR_W-1:0] t_ptr;

    typedef struct packed {
        logic              en;
        logic [1:0]        sel;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_load;

    typedef struct packed {
        logic start;
        t_cnt len_ua;
        t_cnt len_ra;
        t_cnt len_ub;
        t_cnt len_rb;
    } t_walk_req;

    typedef struct packed {
        logic done;
        t_ord order;
    } t_walk_stat;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_nondigit(input logic [7:0] c);
        return (c != CH_NUL) && !is_digit(c);
    endfunction

    // letters weigh their code, tilde sorts first, other symbols after letters
    function automatic logic signed [9:0] weight(input logic [7:0] c);
        logic letter;
        letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
        if ((c == CH_NUL) || is_digit(c)) begin
            return 10'sd0;
        end else if (letter) begin
            return signed'({2'b00, c});
        end else if (c == CH_TILDE) begin
            return -10'sd1;
        end else begin
            return signed'({2'b01, c});
        end
    endfunction

endpackage

@@ rtl/pvc_walker.sv @@
module pvc_walker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pvc_pkg::t_load      i_load,
    input  pvc_pkg::t_walk_req  i_req,
    output pvc_pkg::t_walk_stat o_stat
);
    import pvc_pkg::*;

    typedef enum logic [5:0] {
        W_IDLE   = 6'b000001,
        W_LOOP   = 6'b000010,
        W_NONDIG = 6'b000100,
        W_ZERO   = 6'b001000,
        W_DIGIT  = 6'b010000,
        W_DONE   = 6'b100000
    } t_wstate;

    localparam logic PH_UP  = 1'b0;
    localparam logic PH_REV = 1'b1;

    logic [7:0] r_mem_ua [MAX_CHARS];
    logic [7:0] r_mem_ra [MAX_CHARS];
    logic [7:0] r_mem_ub [MAX_CHARS];
    logic [7:0] r_mem_rb [MAX_CHARS];
    logic [7:0] r_rd_ua, r_rd_ra, r_rd_ub, r_rd_rb;

    t_wstate r_state, n_state;
    logic    r_phase, n_phase;
    t_ptr    r_i, n_i, r_j, n_j;
    t_ord    r_diff, n_diff;
    t_ord    r_ord, n_ord;
    t_cnt    r_len_ua, r_len_ra, r_len_ub, r_len_rb;

    t_cnt       len_a, len_b;
    logic [7:0] ca, cb;
    logic signed [9:0] wa, wb;

    // one byte of each buffer a cycle, read at the next pointer value
    always_ff @(posedge i_clk) begin
        if (i_load.en && (i_load.sel == BUF_UA)) r_mem_ua[i_load.addr] <= i_load.data;
        if (i_load.en && (i_load.sel == BUF_RA)) r_mem_ra[i_load.addr] <= i_load.data;
        if (i_load.en && (i_load.sel == BUF_UB)) r_mem_ub[i_load.addr] <= i_load.data;
        if (i_load.en && (i_load.sel == BUF_RB)) r_mem_rb[i_load.addr] <= i_load.data;
        r_rd_ua <= r_mem_ua[n_i[ADDR_W-1:0]];
        r_rd_ra <= r_mem_ra[n_i[ADDR_W-1:0]];
        r_rd_ub <= r_mem_ub[n_j[ADDR_W-1:0]];
        r_rd_rb <= r_mem_rb[n_j[ADDR_W-1:0]];
    end

    always_comb begin
        len_a = (r_phase == PH_REV) ? r_len_ra : r_len_ua;
        len_b = (r_phase == PH_REV) ? r_len_rb : r_len_ub;
        ca = (r_i < PTR_W'(len_a)) ? ((r_phase == PH_REV) ? r_rd_ra : r_rd_ua) : CH_NUL;
        cb = (r_j < PTR_W'(len_b)) ? ((r_phase == PH_REV) ? r_rd_rb : r_rd_ub) : CH_NUL;
        wa = weight(ca);
        wb = weight(cb);
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_i     = r_i;
        n_j     = r_j;
        n_diff  = r_diff;
        n_ord   = r_ord;
        case (r_state)
            W_IDLE: begin
                if (i_req.start) begin
                    n_state = W_LOOP;
                    n_phase = PH_UP;
                    n_i     = '0;
                    n_j     = '0;
                end
            end
            W_LOOP: begin
                n_diff = ORD_EQ;
                if ((r_i < PTR_W'(len_a)) || (r_j < PTR_W'(len_b))) begin
                    n_state = W_NONDIG;
                end else if (r_phase == PH_UP) begin
                    // upstream equal, go on to the revisions
                    n_phase = PH_REV;
                    n_i     = '0;
                    n_j     = '0;
                end else begin
                    n_ord   = ORD_EQ;
                    n_state = W_DONE;
                end
            end
            W_NONDIG: begin
                if (is_nondigit(ca) || is_nondigit(cb)) begin
                    if (wa != wb) begin
                        n_ord   = (wa < wb) ? ORD_LESS : ORD_GREATER;
                        n_state = W_DONE;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_state = W_ZERO;
                end
            end
            W_ZERO: begin
                // leading zeros skipped on both sides, each side stepping over its own zeros
                if (ca == CH_ZERO) n_i = r_i + 1'b1;
                if (cb == CH_ZERO) n_j = r_j + 1'b1;
                if ((ca != CH_ZERO) && (cb != CH_ZERO)) n_state = W_DIGIT;
            end
            W_DIGIT: begin
                if (is_digit(ca) && is_digit(cb)) begin
                    if ((r_diff == ORD_EQ) && (ca != cb)) begin
                        n_diff = (ca < cb) ? ORD_LESS : ORD_GREATER;
                    end
                    n_i = r_i + 1'b1;
                    n_j = r_j + 1'b1;
                end else if (is_digit(ca)) begin
                    n_ord   = ORD_GREATER;
                    n_state = W_DONE;
                end else if (is_digit(cb)) begin
                    n_ord   = ORD_LESS;
                    n_state = W_DONE;
                end else if (r_diff != ORD_EQ) begin
                    n_ord   = r_diff;
                    n_state = W_DONE;
                end else begin
                    n_state = W_LOOP;
                end
            end
            W_DONE: begin
                n_state = W_IDLE;
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_phase <= n_phase;
        r_i     <= n_i;
        r_j     <= n_j;
        r_diff  <= n_diff;
        r_ord   <= n_ord;
        if (i_req.start && (r_state == W_IDLE)) begin
            r_len_ua <= i_req.len_ua;
            r_len_ra <= i_req.len_ra;
            r_len_ub <= i_req.len_ub;
            r_len_rb <= i_req.len_rb;
        end
    end

    assign o_stat.done  = (r_state == W_DONE);
    assign o_stat.order = r_ord;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == W_IDLE))
        else $error("walk started while busy");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != W_IDLE) && (r_state != W_LOOP) |->
            (r_i <= PTR_W'(len_a) + PTR_W'(len_b)) && (r_j <= PTR_W'(len_a) + PTR_W'(len_b)))
        else $error("walk pointer ran past both strings");

    a_equal_in_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done && (o_stat.order == ORD_EQ) |-> (r_phase == PH_REV))
        else $error("equal result before the revisions were walked");

endmodule

@@ rtl/package_version_comparator_unit.sv @@
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+--------------------------------------------------
// input    | i_in_valid  | o_in_ready  | i_operation i_character i_epoch_a i_epoch_b
//          |             |             | i_relation
// output   | o_out_valid | i_out_ready | o_order o_relation_holds o_bad_relation o_truncated
//
// a load beat gives no result; loads go back to back
// a compare beat with differing epochs skips the walk: its order is registered in the hold
// state and moves to the output register once that is free; with equal epochs the walker
// runs the upstream strings, then the revisions if those tie, before the hold state
// the input is not ready from a compare beat until its result enters the output register
// reset (synchronous, active low) empties the buffers and clears the overflow flag
module package_version_comparator_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_operation,
    input  logic [7:0]        i_character,
    input  logic [30:0]       i_epoch_a,
    input  logic [30:0]       i_epoch_b,
    input  logic [2:0]        i_relation,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [1:0] o_order,
    output logic              o_relation_holds,
    output logic              o_bad_relation,
    output logic              o_truncated
);
    import pvc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    t_state r_state, n_state;

    // fill count per buffer, indexed by the low bits of the load code
    t_cnt r_fill [4];
    logic r_ovf;

    // compare beat held while the walk runs
    t_ord       r_ord;
    logic [2:0] r_rel;
    logic       r_trunc;

    // output register
    logic       r_o_valid;
    t_ord       r_o_order;
    logic       r_o_holds, r_o_bad, r_o_trunc;

    t_load      load;
    t_walk_req  req;
    t_walk_stat w_stat;

    logic       in_beat, load_beat, cmp_beat, push;
    logic [1:0] sel;
    logic       holds, bad;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;
    assign load_beat  = in_beat && (i_operation < OP_CMP) && (i_character != CH_NUL);
    assign cmp_beat   = in_beat && (i_operation == OP_CMP);
    assign sel        = i_operation[1:0];

    // byte goes in only while its buffer has room
    always_comb begin
        load.en   = load_beat && (r_fill[sel] < CNT_W'(MAX_CHARS));
        load.sel  = sel;
        load.addr = r_fill[sel][ADDR_W-1:0];
        load.data = i_character;
    end

    // walk only when the epochs tie
    always_comb begin
        req.start  = cmp_beat && (i_epoch_a == i_epoch_b);
        req.len_ua = r_fill[BUF_UA];
        req.len_ra = r_fill[BUF_RA];
        req.len_ub = r_fill[BUF_UB];
        req.len_rb = r_fill[BUF_RB];
    end

    pvc_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_req   (req),
        .o_stat  (w_stat)
    );

    // result moves to the output register once that is free
    assign push = (r_state == ST_HOLD) && (!r_o_valid || i_out_ready);

    always_comb begin
        holds = 1'b0;
        bad   = 1'b0;
        case (r_rel)
            REL_NONE: holds = 1'b1;
            REL_EQ:   holds = (r_ord == ORD_EQ);
            REL_LT:   holds = (r_ord == ORD_LESS);
            REL_LE:   holds = (r_ord != ORD_GREATER);
            REL_GT:   holds = (r_ord == ORD_GREATER);
            REL_GE:   holds = (r_ord != ORD_LESS);
            default:  bad   = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cmp_beat) n_state = req.start ? ST_WALK : ST_HOLD;
            end
            ST_WALK: begin
                if (w_stat.done) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (push) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '{default: '0};
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmp_beat) begin
                // buffers empty as the compare is taken; the walker keeps the lengths
                r_fill <= '{default: '0};
                r_ovf  <= 1'b0;
            end else if (load.en) begin
                r_fill[sel] <= r_fill[sel] + 1'b1;
            end else if (load_beat) begin
                r_ovf <= 1'b1;
            end
            if (push) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmp_beat) begin
            r_rel   <= i_relation;
            r_trunc <= r_ovf;
            if (i_epoch_a > i_epoch_b) begin
                r_ord <= ORD_GREATER;
            end else if (i_epoch_a < i_epoch_b) begin
                r_ord <= ORD_LESS;
            end else begin
                r_ord <= ORD_EQ;
            end
        end else if ((r_state == ST_WALK) && w_stat.done) begin
            r_ord <= w_stat.order;
        end
        if (push) begin
            r_o_order <= r_ord;
            r_o_holds <= holds;
            r_o_bad   <= bad;
            r_o_trunc <= r_trunc;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_order          = r_o_order;
    assign o_relation_holds = r_o_holds;
    assign o_bad_relation   = r_o_bad;
    assign o_truncated      = r_o_trunc;

    a_bad_not_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_relation |-> !o_relation_holds)
        else $error("invalid relation reported as holding");

    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_order != 2'sb10))
        else $error("order outside -1..1");

    a_cmp_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp_beat |=> (r_fill[BUF_UA] == '0) && (r_fill[BUF_RA] == '0) &&
                     (r_fill[BUF_UB] == '0) && (r_fill[BUF_RB] == '0) && !r_ovf)
        else $error("buffers not emptied by a compare");

    a_done_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == ST_WALK))
        else $error("walker finished outside a walk");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import pvc_pkg::*;

    // op codes the block leaves unused, and relation codes it rejects
    localparam int OP_UNUSED_FIRST = 5;
    localparam int OP_UNUSED_LAST  = 7;
    localparam logic [2:0] REL_BAD_LO = 3'd6;
    localparam logic [2:0] REL_BAD_HI = 3'd7;

    localparam logic [30:0] EPOCH_MAX = 31'h7FFF_FFFF;

    // long receiver hold-off in the back-pressure phase
    localparam int HOLD_CYCLES  = 600;
    // settling time after the last result, covers the slowest walk of full buffers
    localparam int DRAIN_CYCLES = 1000;
    localparam int BEATS_PER_PHASE = 140;

    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESS
    } t_phase;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  ch;
        logic [30:0] ea;
        logic [30:0] eb;
        logic [2:0]  rel;
    } t_beat;

    typedef struct packed {
        t_ord order;
        logic holds;
        logic bad;
        logic trunc;
    } t_verdict;

    logic        i_clk    = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic [2:0]  in_op    = OP_CMP;
    logic [7:0]  in_ch    = CH_NUL;
    logic [30:0] in_ea    = '0;
    logic [30:0] in_eb    = '0;
    logic [2:0]  in_rel   = REL_NONE;
    logic        out_ready = 1'b0;

    logic              in_ready;
    logic              out_valid;
    logic signed [1:0] out_order;
    logic              out_holds;
    logic              out_bad;
    logic              out_trunc;

    t_phase phase = PH_FREE;

    t_beat    pending_beats[$];
    t_verdict expected_verdicts[$];
    int       queued_beats = 0;
    int       mismatches   = 0;

    // receiver hold-off, owned by the monitor
    int hold_left = 0;
    bit hold_used = 1'b0;

    // predictor state: the four byte buffers, their fill and the overflow flag
    logic [7:0] held_bytes [4][MAX_CHARS];
    int         held_len [4] = '{default: 0};
    bit         held_overflow = 1'b0;

    // scratch strings for building a version pair
    logic [7:0] draft [4][80];

    package_version_comparator_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (in_op),
        .i_character      (in_ch),
        .i_epoch_a        (in_ea),
        .i_epoch_b        (in_eb),
        .i_relation       (in_rel),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_order          (out_order),
        .o_relation_holds (out_holds),
        .o_bad_relation   (out_bad),
        .o_truncated      (out_trunc)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit numeric(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // sort weight of a byte in a non-digit run
    function automatic int heft(input logic [7:0] c);
        if ((c == CH_NUL) || numeric(c)) begin
            return 0;
        end
        if (((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"))) begin
            return int'(c);
        end
        if (c == CH_TILDE) begin
            return -1;
        end
        return int'(c) + 256;
    endfunction

    function automatic logic [7:0] byte_at(input int s, input int p);
        return (p < held_len[s]) ? held_bytes[s][p] : CH_NUL;
    endfunction

    // ordering of two held strings: alternating non-digit and digit runs
    function automatic int rank_strings(input int sa, input int sb);
        int i;
        int j;
        int diff;
        int wa;
        int wb;
        logic [7:0] ca;
        logic [7:0] cb;
        i = 0;
        j = 0;
        while ((i < held_len[sa]) || (j < held_len[sb])) begin
            diff = 0;
            ca = byte_at(sa, i);
            cb = byte_at(sb, j);
            while (((ca != CH_NUL) && !numeric(ca)) || ((cb != CH_NUL) && !numeric(cb))) begin
                wa = heft(ca);
                wb = heft(cb);
                if (wa != wb) begin
                    return (wa < wb) ? -1 : 1;
                end
                i++;
                j++;
                ca = byte_at(sa, i);
                cb = byte_at(sb, j);
            end
            // leading zeros carry no weight
            while (byte_at(sa, i) == CH_ZERO) i++;
            while (byte_at(sb, j) == CH_ZERO) j++;
            ca = byte_at(sa, i);
            cb = byte_at(sb, j);
            while (numeric(ca) && numeric(cb)) begin
                if ((diff == 0) && (ca != cb)) begin
                    diff = (ca < cb) ? -1 : 1;
                end
                i++;
                j++;
                ca = byte_at(sa, i);
                cb = byte_at(sb, j);
            end
            // the longer digit run wins before the first differing digit counts
            if (numeric(byte_at(sa, i))) begin
                return 1;
            end
            if (numeric(byte_at(sb, j))) begin
                return -1;
            end
            if (diff != 0) begin
                return diff;
            end
        end
        return 0;
    endfunction

    // update the predictor with one accepted input beat
    function automatic void predict_beat(input t_beat b);
        t_verdict v;
        int r;
        int k;
        if (b.op <= OP_LOAD_RB) begin
            // zero bytes are ignored altogether
            if (b.ch != CH_NUL) begin
                k = int'(b.op);
                if (held_len[k] < MAX_CHARS) begin
                    held_bytes[k][held_len[k]] = b.ch;
                    held_len[k]++;
                end else begin
                    held_overflow = 1'b1;
                end
            end
        end else if (b.op == OP_CMP) begin
            if (b.ea > b.eb) begin
                r = 1;
            end else if (b.ea < b.eb) begin
                r = -1;
            end else begin
                r = rank_strings(BUF_UA, BUF_UB);
                if (r == 0) begin
                    r = rank_strings(BUF_RA, BUF_RB);
                end
            end
            v.order = (r < 0) ? ORD_LESS : ((r > 0) ? ORD_GREATER : ORD_EQ);
            v.bad   = 1'b0;
            case (b.rel)
                REL_NONE: v.holds = 1'b1;
                REL_EQ:   v.holds = (r == 0);
                REL_LT:   v.holds = (r < 0);
                REL_LE:   v.holds = (r <= 0);
                REL_GT:   v.holds = (r > 0);
                REL_GE:   v.holds = (r >= 0);
                default: begin
                    v.holds = 1'b0;
                    v.bad   = 1'b1;
                end
            endcase
            v.trunc = held_overflow;
            expected_verdicts.push_back(v);
            held_len      = '{default: 0};
            held_overflow = 1'b0;
        end
        // unused op codes leave everything untouched
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [2:0] load_op(input int k);
        case (k)
            BUF_UA:  return OP_LOAD_UA;
            BUF_RA:  return OP_LOAD_RA;
            BUF_UB:  return OP_LOAD_UB;
            default: return OP_LOAD_RB;
        endcase
    endfunction

    // version-like bytes: digits, zeros, letters, tilde, separators, anything
    function automatic logic [7:0] pick_char();
        logic [7:0] seps [4];
        seps = '{".", "+", "-", ":"};
        case ($urandom_range(9))
            0, 1, 2: return CH_ZERO + 8'($urandom_range(9));
            3:       return CH_ZERO;
            4:       return "a" + 8'($urandom_range(25));
            5:       return "A" + 8'($urandom_range(25));
            6:       return CH_TILDE;
            7:       return seps[$urandom_range(3)];
            8:       return 8'($urandom_range(255));
            default: return "a" + 8'($urandom_range(2));
        endcase
    endfunction

    task automatic queue_beat(input logic [2:0] op, input logic [7:0] ch,
                              input logic [30:0] ea, input logic [30:0] eb,
                              input logic [2:0] rel);
        t_beat b;
        b.op  = op;
        b.ch  = ch;
        b.ea  = ea;
        b.eb  = eb;
        b.rel = rel;
        pending_beats.push_back(b);
    endtask

    // loads carry random junk in the fields they do not use
    task automatic queue_load(input int k, input logic [7:0] ch);
        queue_beat(load_op(k), ch, 31'($urandom), 31'($urandom), 3'($urandom_range(7)));
        queued_beats++;
    endtask

    task automatic queue_compare(input logic [30:0] ea, input logic [30:0] eb,
                                 input logic [2:0] rel);
        queue_beat(OP_CMP, 8'($urandom_range(255)), ea, eb, rel);
        queued_beats++;
    endtask

    // an ignored beat: unused op code, or a load of a zero byte
    task automatic queue_noise();
        if ($urandom_range(1) == 0) begin
            queue_beat(3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                       8'($urandom_range(255)), 31'($urandom), 31'($urandom),
                       3'($urandom_range(7)));
        end else begin
            queue_beat(load_op($urandom_range(3)), CH_NUL, 31'($urandom), 31'($urandom),
                       3'($urandom_range(7)));
        end
    endtask

    // one version pair: A drawn at random, B a near copy of A or drawn anew, loads interleaved
    task automatic queue_pair(input bit force_long);
        int len [4];
        int pos [4];
        int k;
        int p;
        int left;
        bit long_one;
        logic [30:0] ea;
        logic [30:0] eb;
        long_one = force_long || ($urandom_range(15) == 0);
        for (k = 0; k < 2; k++) begin
            len[k] = (long_one && (k == 0)) ? $urandom_range(70, 60) : $urandom_range(8);
            for (p = 0; p < len[k]; p++) draft[k][p] = pick_char();
        end
        for (k = 2; k < 4; k++) begin
            len[k] = len[k-2];
            for (p = 0; p < len[k]; p++) draft[k][p] = draft[k-2][p];
            case ($urandom_range(5))
                1: if (len[k] > 0) draft[k][$urandom_range(len[k] - 1)] = pick_char();
                2: begin
                    draft[k][len[k]] = pick_char();
                    len[k]++;
                end
                3: if (len[k] > 0) len[k]--;
                4: begin
                    // extra leading zero in front
                    for (p = len[k]; p > 0; p--) draft[k][p] = draft[k][p-1];
                    draft[k][0] = CH_ZERO;
                    len[k]++;
                end
                5: begin
                    len[k] = $urandom_range(8);
                    for (p = 0; p < len[k]; p++) draft[k][p] = pick_char();
                end
                default: ;
            endcase
        end
        left = 0;
        for (k = 0; k < 4; k++) begin
            pos[k] = 0;
            left += len[k];
        end
        while (left > 0) begin
            k = $urandom_range(3);
            if (pos[k] < len[k]) begin
                if ($urandom_range(19) == 0) queue_noise();
                queue_load(k, draft[k][pos[k]]);
                pos[k]++;
                left--;
            end
        end
        case ($urandom_range(7))
            0: begin
                ea = 31'($urandom);
                eb = 31'($urandom);
            end
            1: begin
                ea = 31'($urandom);
                eb = ea;
            end
            2: begin
                eb = 31'($urandom_range(5));
                ea = eb + 31'd1;
            end
            default: begin
                ea = 31'($urandom_range(2));
                eb = ea;
            end
        endcase
        if ($urandom_range(1) == 0) begin
            {ea, eb} = {eb, ea};
        end
        queue_compare(ea, eb, 3'($urandom_range(7)));
    endtask

    // ---------------------------------------------------------------- idling

    function automatic int sender_idle_pct(input t_phase ph);
        case (ph)
            PH_SEND_IDLE: return 71;
            PH_BOTH:      return 30;
            default:      return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input t_phase ph);
        case (ph)
            PH_RECV_STALL: return 71;
            PH_BOTH:       return 30;
            default:       return 0;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver

    // a new beat is offered only once the previous one has gone
    always @(posedge i_clk) begin
        t_beat nb;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_beat({in_op, in_ch, in_ea, in_eb, in_rel});
            end
            if (!in_valid || in_ready) begin
                if ((pending_beats.size() != 0) &&
                    ($urandom_range(99) >= sender_idle_pct(phase))) begin
                    nb = pending_beats.pop_front();
                    in_op    <= nb.op;
                    in_ch    <= nb.ch;
                    in_ea    <= nb.ea;
                    in_eb    <= nb.eb;
                    in_rel   <= nb.rel;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_verdict v;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: result beat with none expected, order %0d holds %0b",
                             $time, out_order, out_holds);
                    $display("%0t: unexpected beat also has bad %0b trunc %0b",
                             $time, out_bad, out_trunc);
                    mismatches++;
                end else begin
                    v = expected_verdicts.pop_front();
                    if (out_order !== v.order) begin
                        $display("%0t: order expected %0d got %0d", $time, v.order, out_order);
                        mismatches++;
                    end
                    if (out_holds !== v.holds) begin
                        $display("%0t: relation_holds expected %0b got %0b",
                                 $time, v.holds, out_holds);
                        mismatches++;
                    end
                    if (out_bad !== v.bad) begin
                        $display("%0t: bad_relation expected %0b got %0b", $time, v.bad, out_bad);
                        mismatches++;
                    end
                    if (out_trunc !== v.trunc) begin
                        $display("%0t: truncated expected %0b got %0b", $time, v.trunc, out_trunc);
                        mismatches++;
                    end
                end
            end
            // long hold-off once the back-pressure phase begins, so the input stalls
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if ((phase == PH_PRESS) && !hold_used) begin
                hold_left <= HOLD_CYCLES;
                hold_used <= 1'b1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= receiver_stall_pct(phase));
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    // sampled on the falling edge, clear of the clocked processes
    task automatic wait_drained();
        while ((pending_beats.size() != 0) || in_valid || (expected_verdicts.size() != 0)) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        t_phase ph;
        bit first;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty strings, epoch extremes, tilde, byte extremes,
        // zero byte, unused ops, leading zeros, every relation code
        phase = PH_FREE;
        queue_compare(31'd0, 31'd0, REL_EQ);
        queue_compare(EPOCH_MAX, 31'd0, REL_GT);
        queue_compare(31'd0, EPOCH_MAX, REL_LT);
        queue_load(BUF_UA, "1");
        queue_load(BUF_UA, CH_TILDE);
        queue_load(BUF_UB, "1");
        queue_compare(31'd3, 31'd3, REL_LE);
        queue_load(BUF_RA, 8'hFF);
        queue_load(BUF_RB, 8'h01);
        queue_load(BUF_UA, CH_NUL);
        queue_compare(31'd0, 31'd0, REL_BAD_LO);
        for (int u = OP_UNUSED_FIRST; u <= OP_UNUSED_LAST; u++) begin
            queue_beat(3'(u), 8'hFF, EPOCH_MAX, EPOCH_MAX, REL_BAD_HI);
        end
        queue_load(BUF_UA, CH_ZERO);
        queue_load(BUF_UA, CH_ZERO);
        queue_load(BUF_UA, "7");
        queue_load(BUF_UB, "7");
        queue_compare(EPOCH_MAX, EPOCH_MAX, REL_GE);
        queue_load(BUF_RA, "a");
        queue_load(BUF_RB, "Z");
        queue_compare(31'd1, 31'd1, REL_BAD_HI);
        queue_compare(EPOCH_MAX, EPOCH_MAX, REL_NONE);
        wait_drained();

        // random pairs under each idling pattern; the very first one has a long string that can overfill a buffer
        first = 1'b1;
        for (int p = PH_FREE; p <= PH_PRESS; p++) begin
            ph = t_phase'(p);
            phase = ph;
            queued_beats = 0;
            while (queued_beats < BEATS_PER_PHASE) begin
                queue_pair(first);
                first = 1'b0;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
